// File: sv/vad_pkg.sv
package vad_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ALPHA_W  = 16;
   localparam int THR_W    = 16;
   localparam int Y_W      = 18;
   localparam int DIFF_W   = 19;
   localparam int PROD_W   = ALPHA_W + 1 + DIFF_W;
   localparam int SCALED_W = PROD_W - 16;
   localparam int MAG_W    = 17;
   localparam int SUM_W    = 33;
   localparam int CNT_W    = 17;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;
   localparam int IDX_W    = 2;

   localparam logic signed [SCALED_W-1:0] Y_MAX = SCALED_W'(131071);
   localparam logic signed [SCALED_W-1:0] Y_MIN = -SCALED_W'(131071);
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam int unsigned COUNT_LIMIT = 131071;

   localparam logic [IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
   localparam logic [IDX_W-1:0] REG_ALPHA_COEFF   = 2'd1;
   localparam logic [IDX_W-1:0] REG_THRESHOLD     = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'hFFFF;
   localparam logic [THR_W-1:0]   THR_RESET   = 16'd1966;

   typedef struct packed {
      logic fire;
      logic last;
   } step_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } frame_type;

endpackage

// File: sv/vad_filter.sv
module vad_filter
   import vad_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  step_type                   step,
   input  logic                       filter_enable,
   input  logic [ALPHA_W-1:0]         alpha_coeff,
   input  logic signed [SAMPLE_W-1:0] sample,
   output logic signed [Y_W-1:0]      y
);

   logic signed [SAMPLE_W-1:0] prev_input_ff, prev_input_in;
   logic signed [Y_W-1:0]      filter_out_ff, filter_out_in;
   logic                       in_frame_ff, in_frame_in;

   logic signed [DIFF_W-1:0]   diff;
   logic signed [PROD_W-1:0]   prod;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [SCALED_W-1:0] scaled;
   logic signed [Y_W-1:0]      y_hp;

   assign diff    = DIFF_W'(filter_out_ff) + DIFF_W'(sample) - DIFF_W'(prev_input_ff);
   assign prod    = $signed({1'b0, alpha_coeff}) * diff;
   assign rounded = prod + PROD_W'(32768);
   assign scaled  = rounded[PROD_W-1:16];

   always_comb begin
      if (scaled > Y_MAX) begin
         y_hp = Y_W'(Y_MAX);
      end else if (scaled < Y_MIN) begin
         y_hp = Y_W'(Y_MIN);
      end else begin
         y_hp = scaled[Y_W-1:0];
      end
   end

   assign y = (!in_frame_ff || !filter_enable) ? Y_W'(sample) : y_hp;

   always_comb begin
      prev_input_in = prev_input_ff;
      filter_out_in = filter_out_ff;
      in_frame_in   = in_frame_ff;
      if (step.fire) begin
         if (step.last) begin
            prev_input_in = '0;
            filter_out_in = '0;
            in_frame_in   = 1'b0;
         end else begin
            prev_input_in = sample;
            filter_out_in = y;
            in_frame_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_input_ff <= '0;
         filter_out_ff <= '0;
         in_frame_ff   <= 1'b0;
      end else begin
         prev_input_ff <= prev_input_in;
         filter_out_ff <= filter_out_in;
         in_frame_ff   <= in_frame_in;
      end
   end

endmodule

// File: sv/vad_accum.sv
module vad_accum
   import vad_pkg::*;
#(
   parameter int unsigned COUNT_CAP = 65536
) (
   input  logic                  clock,
   input  logic                  reset,
   input  step_type              step,
   input  logic signed [Y_W-1:0] y,
   output frame_type             frame
);

   localparam logic [CNT_W-1:0] CAP = CNT_W'(COUNT_CAP);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic signed [Y_W-1:0] y_abs;
   logic [MAG_W-1:0]      mag;
   logic [SUM_W:0]        sum_wide;
   logic                  counting;

   assign y_abs    = y[Y_W-1] ? -y : y;
   assign mag      = y_abs[MAG_W-1:0];
   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(mag);
   assign counting = count_ff < CAP;

   assign frame.sum   = !counting ? sum_ff :
                        (sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0]);
   assign frame.count = counting ? count_ff + CNT_W'(1) : count_ff;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (step.fire) begin
         if (step.last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = frame.sum;
            count_in = frame.count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: sv/vad_decide.sv
module vad_decide
   import vad_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  frame_type          frame,
   input  logic [THR_W-1:0]   energy_threshold,
   output logic               load_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_speech,
   output logic [SUM_W-1:0]   rsp_energy_sum,
   output logic [CNT_W-1:0]   rsp_sample_count
);

   logic      hold_valid_ff, hold_valid_in;
   frame_type hold_ff;
   logic      out_valid_ff, out_valid_in;
   logic      speech_ff;
   frame_type out_ff;

   logic             hold_go;
   logic [SUM_W-1:0] limit;

   assign hold_go    = hold_valid_ff && (!out_valid_ff || rsp_ready);
   assign load_ready = !hold_valid_ff || hold_go;
   assign limit      = SUM_W'(energy_threshold) * SUM_W'(hold_ff.count);

   assign hold_valid_in = load || (hold_valid_ff && !hold_go);
   assign out_valid_in  = hold_go || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= frame;
      end
      if (hold_go) begin
         out_ff    <= hold_ff;
         speech_ff <= hold_ff.sum >= limit;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_speech       = speech_ff;
   assign rsp_energy_sum   = out_ff.sum;
   assign rsp_sample_count = out_ff.count;

endmodule

// File: sv/energy_voice_activity_detector.sv
// Energy voice activity detector. Samples of one frame arrive one beat at a time, with
// req_last_sample marking the end of the frame; optionally they pass a first-order
// high-pass filter (the first sample of each frame is taken as is), and their absolute
// values are summed. On the last sample one result beat reports the saturating sum,
// the sample count and speech = (sum >= energy_threshold * count). The block takes one
// beat per clock: the throughput is set by the filter recurrence, one 17 x 19 bit
// multiply with rounding and saturation, done combinationally. The last sample passes
// the input and hold registers before rsp_valid rises, and a stalled result only
// blocks the input once a second finished frame is waiting behind it. Registers (APB,
// byte address): 0x0 filter_enable, 0x4 alpha_coeff (Q0.16), 0x8 energy_threshold.
module energy_voice_activity_detector
   import vad_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_speech,
   output logic [SUM_W-1:0]           rsp_energy_sum,
   output logic [CNT_W-1:0]           rsp_sample_count,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ADDR_W-1:0]          paddr,
   input  logic [DATA_W-1:0]          pwdata,
   output logic [DATA_W-1:0]          prdata,
   output logic                       pready
);

   localparam int unsigned COUNT_CAP = (MAX_FRAME < COUNT_LIMIT) ? MAX_FRAME : COUNT_LIMIT;

   logic               filter_enable_ff;
   logic [ALPHA_W-1:0] alpha_coeff_ff;
   logic [THR_W-1:0]   threshold_ff;

   logic                       in_valid_ff, in_valid_in;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       in_last_ff;

   logic                  csr_write;
   logic [IDX_W-1:0]      csr_index;
   logic                  load_ready;
   logic                  in_go;
   step_type              step;
   logic signed [Y_W-1:0] y;
   frame_type             frame;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_index = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
         alpha_coeff_ff   <= ALPHA_RESET;
         threshold_ff     <= THR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FILTER_ENABLE: filter_enable_ff <= pwdata[0];
            REG_ALPHA_COEFF:   alpha_coeff_ff   <= pwdata[ALPHA_W-1:0];
            REG_THRESHOLD:     threshold_ff     <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_FILTER_ENABLE: prdata = DATA_W'(filter_enable_ff);
         REG_ALPHA_COEFF:   prdata = DATA_W'(alpha_coeff_ff);
         REG_THRESHOLD:     prdata = DATA_W'(threshold_ff);
         default:           prdata = '0;
      endcase
   end

   assign in_go       = in_valid_ff && (!in_last_ff || load_ready);
   assign req_ready   = !in_valid_ff || in_go;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !in_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample;
         in_last_ff   <= req_last_sample;
      end
   end

   assign step.fire = in_go;
   assign step.last = in_last_ff;

   vad_filter u_filter (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .filter_enable (filter_enable_ff),
      .alpha_coeff   (alpha_coeff_ff),
      .sample        (in_sample_ff),
      .y             (y)
   );

   vad_accum #(
      .COUNT_CAP (COUNT_CAP)
   ) u_accum (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .y     (y),
      .frame (frame)
   );

   vad_decide u_decide (
      .clock            (clock),
      .reset            (reset),
      .load             (in_go && in_last_ff),
      .frame            (frame),
      .energy_threshold (threshold_ff),
      .load_ready       (load_ready),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_speech       (rsp_speech),
      .rsp_energy_sum   (rsp_energy_sum),
      .rsp_sample_count (rsp_sample_count)
   );

endmodule

// File: sv/vad_checker.sv
module vad_checker
   import vad_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic signed [SAMPLE_W-1:0] req_sample,
   input logic                       req_last_sample,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_speech,
   input logic [SUM_W-1:0]           rsp_energy_sum,
   input logic [CNT_W-1:0]           rsp_sample_count,
   input logic                       psel,
   input logic                       penable,
   input logic                       pwrite,
   input logic [ADDR_W-1:0]          paddr,
   input logic [DATA_W-1:0]          pwdata,
   input logic [DATA_W-1:0]          prdata,
   input logic                       pready
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speech)
         && $stable(rsp_energy_sum) && $stable(rsp_sample_count))
      else $error("result beat changed while stalled");

   a_ready_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_ready)
      else $error("input not ready after reset");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample_count != '0)
      else $error("frame reported with zero samples");

   // first sample is unfiltered, so a one-sample frame sums at most full scale
   a_single_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sample_count == CNT_W'(1) |-> rsp_energy_sum <= SUM_W'(32768))
      else $error("one-sample frame sum out of range");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (35'(rsp_energy_sum) <= 35'(rsp_sample_count) * 35'(131071)))
      else $error("energy sum exceeds count times peak level");

endmodule

bind energy_voice_activity_detector vad_checker u_vad_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import vad_pkg::*;

   localparam int unsigned MAX_FRAME = 65536;
   localparam longint unsigned COUNT_CAP = (MAX_FRAME < COUNT_LIMIT) ? MAX_FRAME : COUNT_LIMIT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      bit               speech;
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } frame_result_type;

   class vad_frame_checker;
      bit                 filter_on;
      logic [ALPHA_W-1:0] alpha;
      logic [THR_W-1:0]   threshold;
      bit                 in_frame;
      longint             prev_x;
      longint             prev_y;
      longint unsigned    sum;
      longint unsigned    count;
      frame_result_type   pending_frames[$];
      int                 errors;

      function new();
         filter_on = 1'b0;
         alpha = ALPHA_RESET;
         threshold = THR_RESET;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         in_frame = 1'b0;
         prev_x = 0;
         prev_y = 0;
         sum = 0;
         count = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
         case (idx)
            REG_FILTER_ENABLE: filter_on = value[0];
            REG_ALPHA_COEFF:   alpha = value[ALPHA_W-1:0];
            REG_THRESHOLD:     threshold = value[THR_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] x, logic last);
         longint           xs;
         longint           d;
         longint           y;
         frame_result_type r;
         xs = x;
         if (!in_frame || !filter_on) begin
            y = xs;
         end else begin
            d = prev_y + xs - prev_x;
            // Q0.16 multiply, round half up, symmetric saturation
            y = (longint'(alpha) * d + 32768) >>> 16;
            if (y > longint'(Y_MAX)) y = longint'(Y_MAX);
            if (y < longint'(Y_MIN)) y = longint'(Y_MIN);
         end
         prev_x = xs;
         prev_y = y;
         in_frame = 1'b1;
         if (count < COUNT_CAP) begin
            sum += (y < 0) ? -y : y;
            if (sum > SUM_MAX) sum = SUM_MAX;
            count++;
         end
         if (last) begin
            r.speech = (sum >= threshold * count);
            r.sum = sum[SUM_W-1:0];
            r.count = count[CNT_W-1:0];
            pending_frames.push_back(r);
            clear_frame();
         end
      endfunction

      task report(string msg);
         $display("ERROR t=%0t: %s", $time, msg);
         errors++;
      endtask

      task check_frame(bit speech, logic [SUM_W-1:0] s, logic [CNT_W-1:0] c);
         frame_result_type r;
         if (pending_frames.size() == 0) begin
            report($sformatf("unexpected result beat sum=%0d count=%0d", s, c));
         end else begin
            r = pending_frames.pop_front();
            if (speech !== r.speech)
               report($sformatf("speech %0b, want %0b", speech, r.speech));
            if (s !== r.sum)
               report($sformatf("energy_sum %0d, want %0d", s, r.sum));
            if (c !== r.count)
               report($sformatf("sample_count %0d, want %0d", c, r.count));
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last_sample = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_speech;
   logic [SUM_W-1:0]           rsp_energy_sum;
   logic [CNT_W-1:0]           rsp_sample_count;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [ADDR_W-1:0]          paddr = '0;
   logic [DATA_W-1:0]          pwdata = '0;
   logic [DATA_W-1:0]          prdata;
   logic                       pready;

   vad_frame_checker tracker;
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycles = 0;

   energy_voice_activity_detector #(.MAX_FRAME(MAX_FRAME)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_speech(rsp_speech),
      .rsp_energy_sum(rsp_energy_sum),
      .rsp_sample_count(rsp_sample_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_frame(rsp_speech, rsp_energy_sum, rsp_sample_count);
   end

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.set_reg(idx, value);
   endtask

   task automatic send_beat(input logic [SAMPLE_W-1:0] x, input logic last);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_valid <= 1'b1;
      req_sample <= x;
      req_last_sample <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_sample(x, last);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (tracker.pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] s;
      case ($urandom_range(9))
         0:       s = 16'h8000;
         1:       s = 16'h7FFF;
         2:       s = SAMPLE_W'($urandom_range(200)) - 16'd100;
         3, 4:    s = SAMPLE_W'($urandom_range(4000)) - 16'd2000;
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   task automatic send_frame(input int len, input bit close);
      for (int i = 0; i < len; i++)
         send_beat(pick_sample(), close && (i == len - 1));
   endtask

   task automatic set_regs(input bit en, input logic [ALPHA_W-1:0] a,
                           input logic [THR_W-1:0] t);
      csr_write(REG_FILTER_ENABLE, DATA_W'(en));
      csr_write(REG_ALPHA_COEFF, DATA_W'(a));
      csr_write(REG_THRESHOLD, DATA_W'(t));
   endtask

   initial begin
      int len;
      int sent;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: filter off, threshold boundary
      send_beat(16'h8000, 1'b1);
      send_beat(16'h7FFF, 1'b1);
      send_beat(16'h0000, 1'b1);
      send_beat(16'd1966, 1'b0);
      send_beat(-16'sd1966, 1'b1);
      send_beat(16'd1965, 1'b1);
      wait_idle();

      // full-scale swings through the filter with the largest alpha and a zero threshold
      set_regs(1'b1, 16'hFFFF, 16'd0);
      send_beat(16'h7FFF, 1'b0);
      send_beat(16'h8000, 1'b0);
      send_beat(16'h7FFF, 1'b0);
      send_beat(16'h8000, 1'b1);
      send_beat(16'h8000, 1'b0);
      send_beat(16'h7FFF, 1'b1);
      wait_idle();

      set_regs(1'b1, 16'h0000, 16'hFFFF);
      send_beat(16'd1000, 1'b0);
      send_beat(16'd5000, 1'b0);
      send_beat(-16'sd7, 1'b1);
      // filter toggled in the middle of a frame
      send_beat(16'd1200, 1'b0);
      send_beat(-16'sd3000, 1'b0);
      wait_idle();
      csr_write(REG_FILTER_ENABLE, DATA_W'(0));
      send_beat(16'd3000, 1'b1);
      send_beat(16'd500, 1'b0);
      wait_idle();
      set_regs(1'b1, 16'd40000, 16'd100);
      send_beat(16'd600, 1'b0);
      send_beat(16'd700, 1'b1);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin
               gap_pct = 0; stall_pct = 0;
               set_regs(1'b0, ALPHA_W'($urandom), THR_W'($urandom_range(20000)));
            end
            1: begin
               gap_pct = 52; stall_pct = 0;
               set_regs(1'b1, 16'hFFFF, 16'd0);
            end
            2: begin
               gap_pct = 0; stall_pct = 52;
               set_regs(1'b1, ALPHA_W'($urandom), 16'hFFFF);
            end
            3: begin
               gap_pct = 8; stall_pct = 8;
               set_regs(1'b1, 16'h0000, THR_W'($urandom_range(20000)));
            end
            4: begin
               gap_pct = 0; stall_pct = 0;
               set_regs(1'($urandom_range(1)), ALPHA_W'($urandom),
                        THR_W'($urandom_range(20000)));
            end
            default: begin
               gap_pct = 0; stall_pct = 0;
               set_regs(1'b1, ALPHA_W'($urandom), THR_W'($urandom_range(20000)));
            end
         endcase
         if (p == 4) begin
            // long output stall while short frames keep arriving
            hold_seq <= hold_seq + 1;
            for (int f = 0; f < 40; f++)
               send_frame($urandom_range(2, 1), 1'b1);
         end else begin
            sent = 0;
            while (sent < 110) begin
               len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
               send_frame(len, 1'b1);
               sent += len;
            end
            if ($urandom_range(1))
               send_frame($urandom_range(3, 1), 1'b0);
         end
         wait_idle();
      end

      if (tracker.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
